### rtl/mwc_pkg.sv
// Shared types, constants and codes for the multiply-with-carry generator block.
// No dependencies; used by every other file of the block.
package mwc_pkg;

	localparam int GEN_W   = 32;
	localparam int HALF_W  = 16;
	localparam int BOUND_W = 49;
	localparam int RES_W   = 48;
	localparam int CHUNK_W = HALF_W + 1;
	localparam int CNT_W   = 3;
	localparam int TRY_W   = 6;
	localparam int CFG_IDX_W = 1;

	localparam int BOUND_BITS = 48;

	localparam logic [BOUND_W-1:0] BOUND_LIMIT = BOUND_W'(1) << BOUND_BITS;
	localparam logic [HALF_W-1:0]  MULT_FIRST  = 16'd36969;
	localparam logic [HALF_W-1:0]  MULT_SECOND = 16'd18000;
	localparam logic [HALF_W-1:0]  LOW_ONES    = 16'hFFFF;
	localparam logic [CHUNK_W-1:0] CHUNK_FULL  = 17'h10000;
	localparam logic [GEN_W-1:0]   SEED_FIRST_RST  = 32'd1234;
	localparam logic [GEN_W-1:0]   SEED_SECOND_RST = 32'd5678;
	localparam logic [TRY_W-1:0]   TRY_LAST = 6'd63;

	localparam logic [CFG_IDX_W-1:0] REG_SEED_FIRST  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_SECOND = 1'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_STEP,
		ST_ACC,
		ST_CHECK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic step;
		logic acc;
		logic retry;
		logic res_word;
		logic res_value;
		logic res_zero;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic cnt_last;
		logic hit;
		logic tries_last;
	} dp_status_t;

endpackage

### rtl/mwc_ctrl.sv
// Controller: sequences load, generator steps, chunk accumulation and retries.
// Depends on mwc_pkg; drives mwc_dp through dp_cmd_t.
module mwc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                func,
	output logic                out_valid,
	input  logic                out_stall,
	input  mwc_pkg::dp_status_t status,
	output mwc_pkg::dp_cmd_t    cmd
);
	import mwc_pkg::*;

	state_t state_q, state_d;
	logic   func_q;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			func_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				func_q <= func;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = func ? ST_SETUP : ST_STEP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				if (status.n_zero) begin
					cmd.res_zero = 1'b1;
					state_d      = ST_DONE;
				end else begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				if (func_q) begin
					state_d = ST_ACC;
				end else begin
					cmd.res_word = 1'b1;
					state_d      = ST_DONE;
				end
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = status.cnt_last ? ST_CHECK : ST_STEP;
			end
			ST_CHECK: begin
				if (status.hit) begin
					cmd.res_value = 1'b1;
					state_d       = ST_DONE;
				end else if (status.tries_last) begin
					cmd.res_zero = 1'b1;
					state_d      = ST_DONE;
				end else begin
					cmd.retry = 1'b1;
					state_d   = ST_STEP;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/mwc_dp.sv
// Datapath: the two generators, bound clamp and mask, chunk accumulator,
// rejection test and output register. Depends on mwc_pkg; driven by mwc_ctrl.
module mwc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mwc_pkg::dp_cmd_t              cmd,
	output mwc_pkg::dp_status_t           status,
	input  logic [mwc_pkg::BOUND_W-1:0]   bound,
	input  logic                          cfg_we,
	input  logic [mwc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mwc_pkg::GEN_W-1:0]     cfg_wdata,
	output logic [mwc_pkg::RES_W-1:0]     result_value,
	output logic [mwc_pkg::GEN_W-1:0]     seed_first_now,
	output logic [mwc_pkg::GEN_W-1:0]     seed_second_now
);
	import mwc_pkg::*;

	function automatic logic [BOUND_W-1:0] smear(input logic [BOUND_W-1:0] x);
		logic [BOUND_W-1:0] r;
		r = x;
		for (int k = 0; k < 6; k++) begin
			r = r | (r >> (1 << k));
		end
		return r;
	endfunction

	logic [GEN_W-1:0]   gen_a_q, gen_b_q;
	logic [GEN_W-1:0]   a_next, b_next;
	logic [BOUND_W-1:0] n_q, mask_q, v_q, n_clamp, mask_new;
	logic [CNT_W-1:0]   chunks_q, cnt_q, chunks_new;
	logic [TRY_W-1:0]   tries_q;
	logic [CHUNK_W-1:0] chunk;
	logic [RES_W-1:0]   res_q, result_value_q;
	logic [GEN_W-1:0]   seed_first_q, seed_second_q;

	assign a_next = ({16'b0, MULT_FIRST} * {16'b0, gen_a_q[15:0]}) + {16'b0, gen_a_q[31:16]};
	assign b_next = ({16'b0, MULT_SECOND} * {16'b0, gen_b_q[15:0]}) + {16'b0, gen_b_q[31:16]};

	// word = {a[15:0], b[15:0]}; its top half is the chunk, all-ones word gives 2^16
	assign chunk = (gen_a_q[15:0] == LOW_ONES && gen_b_q[15:0] == LOW_ONES) ?
		CHUNK_FULL : {1'b0, gen_a_q[15:0]};

	assign n_clamp    = (bound > BOUND_LIMIT) ? BOUND_LIMIT : bound;
	assign mask_new   = smear(n_q - BOUND_W'(1));
	assign chunks_new = CNT_W'(1) + CNT_W'(mask_new[15]) + CNT_W'(mask_new[31])
		+ CNT_W'(mask_new[47]);

	assign status.n_zero     = (n_q == '0);
	assign status.cnt_last   = (cnt_q == CNT_W'(1));
	assign status.hit        = ((v_q & mask_q) < n_q);
	assign status.tries_last = (tries_q == TRY_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_a_q  <= SEED_FIRST_RST;
			gen_b_q  <= SEED_SECOND_RST;
			chunks_q <= '0;
			cnt_q    <= '0;
			tries_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SEED_FIRST:  gen_a_q <= cfg_wdata;
					REG_SEED_SECOND: gen_b_q <= cfg_wdata;
					default: ;
				endcase
			end else if (cmd.step) begin
				gen_a_q <= a_next;
				gen_b_q <= b_next;
			end
			if (cmd.setup) begin
				chunks_q <= chunks_new;
				cnt_q    <= chunks_new;
				tries_q  <= '0;
			end else if (cmd.retry) begin
				cnt_q   <= chunks_q;
				tries_q <= tries_q + TRY_W'(1);
			end else if (cmd.acc) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= n_clamp;
		end
		if (cmd.setup) begin
			mask_q <= mask_new;
		end
		if (cmd.setup || cmd.retry) begin
			v_q <= '0;
		end else if (cmd.acc) begin
			v_q <= (v_q << HALF_W) + BOUND_W'(chunk);
		end
		if (cmd.res_word) begin
			res_q <= RES_W'({a_next[15:0], b_next[15:0]});
		end else if (cmd.res_value) begin
			res_q <= RES_W'(v_q & mask_q);
		end else if (cmd.res_zero) begin
			res_q <= '0;
		end
		if (cmd.out_load) begin
			result_value_q <= res_q;
			seed_first_q   <= gen_a_q;
			seed_second_q  <= gen_b_q;
		end
	end

	assign result_value    = result_value_q;
	assign seed_first_now  = seed_first_q;
	assign seed_second_now = seed_second_q;

endmodule

### rtl/mwc_random_with_bounded_index.sv
// Word request (func 0): a single generator step gives the word.
// Index request (func 1): zero for a zero bound; else each attempt accumulates 1..4 chunks,
// one generator step per chunk, then checks; at most 64 attempts. One request at a time;
// the next is taken while a finished result waits in the output register.
// Reset: generators return to 1234 and 5678, no result is pending.
// Top level: joins mwc_ctrl and mwc_dp; depends on mwc_pkg.
module mwc_random_with_bounded_index (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          func,
	input  logic [mwc_pkg::BOUND_W-1:0]   bound,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mwc_pkg::RES_W-1:0]     result_value,
	output logic [mwc_pkg::GEN_W-1:0]     seed_first_now,
	output logic [mwc_pkg::GEN_W-1:0]     seed_second_now,
	input  logic                          cfg_we,
	input  logic [mwc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mwc_pkg::GEN_W-1:0]     cfg_wdata
);
	import mwc_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	mwc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	mwc_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.bound           (bound),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.result_value    (result_value),
		.seed_first_now  (seed_first_now),
		.seed_second_now (seed_second_now)
	);

endmodule

### rtl/mwc_checker.sv
// Port-level checks for mwc_random_with_bounded_index, attached by bind.
// Depends on mwc_pkg for port widths.
module mwc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          func,
	input logic [mwc_pkg::BOUND_W-1:0]   bound,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [mwc_pkg::RES_W-1:0]     result_value,
	input logic [mwc_pkg::GEN_W-1:0]     seed_first_now,
	input logic [mwc_pkg::GEN_W-1:0]     seed_second_now,
	input logic                          cfg_we,
	input logic [mwc_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [mwc_pkg::GEN_W-1:0]     cfg_wdata
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_value)
		&& $stable(seed_first_now) && $stable(seed_second_now))
		else $error("stalled result changed");

	// one request in flight
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while busy");

	// a new result only appears from a busy cycle
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a request in flight");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result valid during reset");

endmodule

bind mwc_random_with_bounded_index mwc_checker u_chk (.*);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for mwc_random_with_bounded_index: a directed table of requests and seed loads,
// then random request phases, every result checked against an in-bench generator model or a table value.
// Depends on mwc_pkg and the block's RTL.
module tb_top;
	import mwc_pkg::*;

	localparam int          PHASES      = 5;
	localparam int          PHASE_LEN   = 265;
	localparam longint      CYCLE_LIMIT = 3_000_000;
	localparam int          SETTLE      = 12;
	localparam int          TRY_MAX     = 64;
	localparam logic [31:0] MUL_A       = 32'd36969;
	localparam logic [31:0] MUL_B       = 32'd18000;
	localparam logic [48:0] N_LIMIT     = 49'h1_0000_0000_0000;

	typedef enum logic {ROW_DRAW, ROW_SEED} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic                  func;
		logic [48:0]           bound;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [31:0]           seed;
		logic                  known;
		logic [47:0]           want;
	} plan_row_t;

	typedef struct packed {
		logic [47:0] value;
		logic [31:0] first;
		logic [31:0] second;
	} draw_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 func = 1'b0;
	logic [BOUND_W-1:0]   bound = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [RES_W-1:0]     result_value;
	logic [GEN_W-1:0]     seed_first_now;
	logic [GEN_W-1:0]     seed_second_now;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [GEN_W-1:0]     cfg_wdata = '0;

	logic [31:0] gen_a = 32'd1234;
	logic [31:0] gen_b = 32'd5678;
	draw_t       draws_due[$];
	plan_row_t   plan[$];
	bit          calm = 1'b0;
	int          errors = 0;
	longint      cycles = 0;

	mwc_random_with_bounded_index u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.bound           (bound),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.result_value    (result_value),
		.seed_first_now  (seed_first_now),
		.seed_second_now (seed_second_now),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[mwc_random_with_bounded_index] ERROR");
			$finish;
		end
	end

	always @(negedge clk)
		out_stall <= !calm && ($urandom_range(0, 99) < 6);

	// generator model
	function automatic logic [31:0] step_pair();
		logic [31:0] na, nb;
		na = MUL_A * {16'd0, gen_a[15:0]} + {16'd0, gen_a[31:16]};
		nb = MUL_B * {16'd0, gen_b[15:0]} + {16'd0, gen_b[31:16]};
		gen_a = na;
		gen_b = nb;
		return {na[15:0], nb[15:0]};
	endfunction

	function automatic logic [16:0] next_chunk();
		logic [31:0] w;
		w = step_pair();
		return (w == 32'hFFFF_FFFF) ? 17'h1_0000 : {1'b0, w[31:16]};
	endfunction

	function automatic logic [47:0] index_below(logic [48:0] n_req);
		logic [48:0] n, top;
		logic [63:0] v, mask;
		int width, pieces;
		n = (n_req > N_LIMIT) ? N_LIMIT : n_req;
		if (n == 49'd0)
			return 48'd0;
		top = n - 49'd1;
		width = 0;
		for (int k = 0; k < 49; k++)
			if (top[k])
				width = k + 1;
		pieces = width / 16 + 1;
		mask = (64'd1 << width) - 64'd1;
		// give up after the last attempt, as the block does
		for (int t = 0; t < TRY_MAX; t++) begin
			v = 64'd0;
			for (int p = 0; p < pieces; p++)
				v = (v << 16) + 64'(next_chunk());
			v &= mask;
			if (v < 64'(n))
				return v[47:0];
		end
		return 48'd0;
	endfunction

	function automatic draw_t draw_result(logic f, logic [48:0] n);
		draw_t d;
		d.value = f ? index_below(n) : {16'd0, step_pair()};
		d.first = gen_a;
		d.second = gen_b;
		return d;
	endfunction

	// table rows
	function automatic plan_row_t ask(logic f, logic [48:0] n);
		plan_row_t r;
		r = '0;
		r.kind = ROW_DRAW;
		r.func = f;
		r.bound = n;
		return r;
	endfunction

	function automatic plan_row_t ask_known(logic f, logic [48:0] n, logic [47:0] want);
		plan_row_t r;
		r = ask(f, n);
		r.known = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic plan_row_t load_seed(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		plan_row_t r;
		r = '0;
		r.kind = ROW_SEED;
		r.reg_idx = idx;
		r.seed = val;
		return r;
	endfunction

	task automatic send_request(logic f, logic [48:0] n, logic known, logic [47:0] want);
		draw_t d;
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 6) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		bound <= n;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		d = draw_result(f, n);
		if (known)
			d.value = want;
		draws_due.push_back(d);
	endtask

	task automatic drain_requests();
		@(negedge clk);
		in_valid <= 1'b0;
		while (draws_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_seed(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		drain_requests();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SEED_FIRST)
			gen_a = val;
		else
			gen_b = val;
	endtask

	task automatic send_random();
		logic [48:0] n, noise;
		int w;
		noise = 49'({$urandom, $urandom});
		w = $urandom_range(1, 48);
		case ($urandom_range(0, 9))
			0: n = 49'($urandom_range(0, 3));
			1: n = N_LIMIT | noise;
			2: n = N_LIMIT >> $urandom_range(0, 48);
			default: n = (noise & ((49'd1 << w) - 49'd1)) | (49'd1 << (w - 1));
		endcase
		send_request($urandom_range(0, 3) != 0, n, 1'b0, 48'd0);
	endtask

	always @(posedge clk) begin : watch_results
		draw_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (draws_due.size() == 0) begin
				$error("unexpected result: result_value %h", result_value);
				errors++;
			end else begin
				due = draws_due.pop_front();
				if (result_value !== due.value) begin
					$error("result_value: expected %h, got %h", due.value, result_value);
					errors++;
				end
				if (seed_first_now !== due.first) begin
					$error("seed_first_now: expected %h, got %h", due.first, seed_first_now);
					errors++;
				end
				if (seed_second_now !== due.second) begin
					$error("seed_second_now: expected %h, got %h", due.second, seed_second_now);
					errors++;
				end
			end
		end
	end

	initial begin : run
		plan_row_t row;
		int hold_at;

		// reset seeds
		plan.push_back(ask_known(1'b0, 49'd0, 48'h1A22_8260));
		plan.push_back(ask_known(1'b1, 49'd0, 48'd0));
		plan.push_back(ask_known(1'b1, 49'd1, 48'd0));
		plan.push_back(ask(1'b1, 49'd2));
		plan.push_back(ask(1'b1, 49'h0_FFFF));
		plan.push_back(ask(1'b1, 49'h1_0000));
		plan.push_back(ask(1'b1, 49'h1_0001));
		plan.push_back(ask(1'b1, 49'h1_0000_0000));
		plan.push_back(ask(1'b1, 49'h1_0000_0001));
		plan.push_back(ask(1'b1, 49'h0_FFFF_FFFF_FFFF));
		plan.push_back(ask(1'b1, N_LIMIT));
		plan.push_back(ask(1'b1, 49'h1_FFFF_FFFF_FFFF));
		plan.push_back(ask(1'b1, N_LIMIT + 49'd1));
		plan.push_back(ask(1'b0, 49'h1_FFFF_FFFF_FFFF));
		plan.push_back(ask(1'b1, 49'h0_5555_5555_5555));
		// both generators parked: every word all ones
		plan.push_back(load_seed(REG_SEED_FIRST, 32'h9068_FFFF));
		plan.push_back(load_seed(REG_SEED_SECOND, 32'h464F_FFFF));
		plan.push_back(ask_known(1'b0, 49'd0, 48'hFFFF_FFFF));
		plan.push_back(ask_known(1'b1, 49'h1_0001, 48'h1_0000));
		plan.push_back(ask_known(1'b1, 49'd3, 48'd0));
		// first parked, second zero: every attempt rejected
		plan.push_back(load_seed(REG_SEED_SECOND, 32'd0));
		plan.push_back(ask_known(1'b1, 49'd3, 48'd0));
		plan.push_back(ask_known(1'b1, 49'h0_FFFF, 48'd0));
		plan.push_back(ask_known(1'b0, 49'd0, 48'hFFFF_0000));
		plan.push_back(load_seed(REG_SEED_FIRST, 32'd0));
		plan.push_back(load_seed(REG_SEED_SECOND, 32'hFFFF_FFFF));
		plan.push_back(ask(1'b0, 49'd0));
		plan.push_back(ask(1'b1, N_LIMIT));
		plan.push_back(load_seed(REG_SEED_FIRST, 32'hFFFF_FFFF));
		plan.push_back(load_seed(REG_SEED_SECOND, 32'd0));
		plan.push_back(ask(1'b0, 49'd0));
		plan.push_back(ask(1'b1, 49'd1000));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			row = plan[i];
			if (row.kind == ROW_SEED)
				write_seed(row.reg_idx, row.seed);
			else
				send_request(row.func, row.bound, row.known, row.want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 2) begin
				write_seed(REG_SEED_FIRST, 32'hFFFF_FFFF);
				write_seed(REG_SEED_SECOND, 32'hFFFF_FFFF);
			end else begin
				write_seed(REG_SEED_FIRST, $urandom);
				write_seed(REG_SEED_SECOND, $urandom);
			end
			calm = (ph == 3);
			hold_at = $urandom_range(20, PHASE_LEN - 20);
			for (int k = 0; k < PHASE_LEN; k++) begin
				if (k == hold_at)
					drain_requests();
				send_random();
			end
		end
		calm = 1'b0;

		drain_requests();
		if (errors == 0)
			$display("[mwc_random_with_bounded_index] OK");
		else
			$display("[mwc_random_with_bounded_index] ERROR");
		$finish;
	end

endmodule

### mwc_random_with_bounded_index.f
rtl/mwc_pkg.sv
rtl/mwc_ctrl.sv
rtl/mwc_dp.sv
rtl/mwc_random_with_bounded_index.sv
rtl/mwc_checker.sv
tb/sv/tb_top.sv
